// ===== hdl/piq_pkg.sv =====
// Shared types and constants for the positional insert queue.
`timescale 1ns / 1ps

package piq_pkg;

    // Default sizing and fixed field widths
    localparam int C_DEPTH      = 16;
    localparam int C_DATA_WIDTH = 32;
    localparam int C_DEPTH_MAX  = 256;
    localparam int C_WORD_W     = 32;
    localparam int C_POS_W      = 5;
    localparam int C_COUNT_W    = 5;
    localparam int C_IDX_W      = $clog2(C_DEPTH_MAX);

    // Operation codes carried in the input word
    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_POP    = 2'd1,
        FN_INSERT = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    // Status codes carried in the result word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Movement broadcast along the chain of cells
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    typedef struct packed {
        t_func                func;
        logic [C_WORD_W-1:0]  data_in;
        logic [C_POS_W-1:0]   position;
    } t_in_word;

    typedef struct packed {
        logic [C_WORD_W-1:0]  data_out;
        logic [C_COUNT_W-1:0] entry_count;
        t_status              status;
    } t_out_word;

    // Command seen by every cell: what to do and the 0-based slot it starts at
    typedef struct packed {
        t_shift              shift;
        logic [C_IDX_W-1:0]  slot;
    } t_cell_cmd;

endpackage

// ===== hdl/piq_cell.sv =====
// One storage cell of the queue chain: holds a single entry.
`timescale 1ns / 1ps

module piq_cell #(
    parameter int P_INDEX      = 0,
    parameter int P_DATA_WIDTH = piq_pkg::C_DATA_WIDTH
) (
    input  logic                    i_clk,
    input  piq_pkg::t_cell_cmd      i_cmd,
    input  logic [P_DATA_WIDTH-1:0] i_word,
    input  logic [P_DATA_WIDTH-1:0] i_prev,
    input  logic [P_DATA_WIDTH-1:0] i_next,
    output logic [P_DATA_WIDTH-1:0] o_word
);
    import piq_pkg::*;

    localparam logic [C_IDX_W-1:0] L_IDX = C_IDX_W'(P_INDEX);

    logic [P_DATA_WIDTH-1:0] r_word;
    logic [P_DATA_WIDTH-1:0] n_word;

    // Pick load, move back, move forward or hold from this cell's place
    always_comb begin
        n_word = r_word;
        case (i_cmd.shift)
            SH_INSERT: begin
                if (L_IDX == i_cmd.slot) begin
                    n_word = i_word;
                end else if (L_IDX > i_cmd.slot) begin
                    n_word = i_prev;
                end
            end
            SH_REMOVE: begin
                if (L_IDX >= i_cmd.slot) begin
                    n_word = i_next;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== hdl/piq_ctrl.sv =====
// Queue controller: checks each operation, keeps the fill count and the result register.
`timescale 1ns / 1ps

module piq_ctrl #(
    parameter int P_DEPTH = piq_pkg::C_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  piq_pkg::t_in_word                 i_in,
    output logic                              o_in_stall,
    input  logic [piq_pkg::C_WORD_W-1:0]      i_head,
    output piq_pkg::t_cell_cmd                o_cmd,
    output logic                              o_out_valid,
    output piq_pkg::t_out_word                o_out,
    input  logic                              i_out_stall
);
    import piq_pkg::*;

    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > C_POS_W) ? CNT_W : C_POS_W) + 1;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;
    t_cell_cmd        n_cmd;
    logic             w_fire;
    logic             w_full;
    logic             w_empty;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;

    // Accept a new word unless a finished result is waiting and held off
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_fire     = i_in_valid & ~o_in_stall;

    assign w_full  = (r_count == CNT_W'(P_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_pos   = CMP_W'(i_in.position);
    assign w_cnt   = CMP_W'(r_count);

    // Decode the operation, refuse it on empty, full or a bad position
    always_comb begin
        t_status st;
        logic [C_WORD_W-1:0] removed;
        st         = ST_OK;
        removed    = '0;
        n_count    = r_count;
        n_cmd.shift = SH_HOLD;
        n_cmd.slot  = '0;
        case (i_in.func)
            FN_APPEND: begin
                if (w_full) begin
                    st = ST_FULL;
                end else begin
                    n_cmd.shift = SH_INSERT;
                    n_cmd.slot  = C_IDX_W'(r_count);
                    n_count     = r_count + 1'b1;
                end
            end
            FN_POP: begin
                if (w_empty) begin
                    st = ST_EMPTY;
                end else begin
                    n_cmd.shift = SH_REMOVE;
                    n_cmd.slot  = '0;
                    removed     = i_head;
                    n_count     = r_count - 1'b1;
                end
            end
            FN_INSERT: begin
                if (w_full) begin
                    st = ST_FULL;
                end else if (w_pos == '0 || w_pos > w_cnt + 1'b1) begin
                    st = ST_RANGE;
                end else begin
                    n_cmd.shift = SH_INSERT;
                    n_cmd.slot  = C_IDX_W'(w_pos - 1'b1);
                    n_count     = r_count + 1'b1;
                end
            end
            FN_REMOVE: begin
                if (w_empty) begin
                    st = ST_EMPTY;
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    st = ST_RANGE;
                end else begin
                    n_cmd.shift = SH_REMOVE;
                    n_cmd.slot  = C_IDX_W'(w_pos - 1'b1);
                    n_count     = r_count - 1'b1;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
        n_out.data_out    = removed;
        n_out.entry_count = C_COUNT_W'(n_count);
        n_out.status      = st;
    end

    // Drive the chain only for an accepted word
    always_comb begin
        o_cmd = n_cmd;
        if (!w_fire) begin
            o_cmd.shift = SH_HOLD;
        end
    end

    // Advance the fill count and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/positional_insert_queue_top.sv =====
// Top level of the positional insert queue: controller and chain of cells.
`timescale 1ns / 1ps
// Result: registered when its word is accepted, so it appears in the next cycle.
// Throughput: one word per cycle; every cell moves its entry in the same cycle,
// and the next word waits only while a result is held off by the output stall.
// Reset: synchronous, active low; clears the fill count and the result valid.
// Cell contents are not reset; only slots below the fill count are ever read.

module positional_insert_queue_top #(
    parameter int P_DEPTH      = piq_pkg::C_DEPTH,
    parameter int P_DATA_WIDTH = piq_pkg::C_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  piq_pkg::t_in_word  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output piq_pkg::t_out_word o_out,
    input  logic               i_out_stall
);
    import piq_pkg::*;

    localparam int WIDE_W = (P_DATA_WIDTH > C_WORD_W) ? P_DATA_WIDTH : C_WORD_W;

    t_cell_cmd               w_cmd;
    logic [WIDE_W-1:0]       w_in_wide;
    logic [WIDE_W-1:0]       w_head_wide;
    logic [P_DATA_WIDTH-1:0] w_word_in;
    logic [P_DATA_WIDTH-1:0] w_cell_q [P_DEPTH];

    // Fit the port word to the stored width and back
    assign w_in_wide   = WIDE_W'(i_in.data_in);
    assign w_word_in   = w_in_wide[P_DATA_WIDTH-1:0];
    assign w_head_wide = WIDE_W'(w_cell_q[0]);

    piq_ctrl #(
        .P_DEPTH (P_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_head      (w_head_wide[C_WORD_W-1:0]),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // Build the chain; each cell sees its two neighbours
    for (genvar g = 0; g < P_DEPTH; g++) begin : g_cell
        logic [P_DATA_WIDTH-1:0] w_prev;
        logic [P_DATA_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_word_in;
        end else begin : g_mid_prev
            assign w_prev = w_cell_q[g-1];
        end

        if (g == P_DEPTH - 1) begin : g_last
            assign w_next = w_cell_q[g];
        end else begin : g_mid_next
            assign w_next = w_cell_q[g+1];
        end

        piq_cell #(
            .P_INDEX      (g),
            .P_DATA_WIDTH (P_DATA_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_word (w_word_in),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_word (w_cell_q[g])
        );
    end

endmodule
